// ===== hdl/obis_pkg.sv =====
// package: sizes, codes, payload types and bit-scan helpers for the offset bitmap id set
package obis_pkg;

	localparam int WORDS = 16;
	localparam int WORD_BITS = 64;
	localparam int CAPACITY = WORDS * WORD_BITS;
	localparam int ID_W = 32;
	localparam int CNT_W = 11;
	localparam int WADDR_W = $clog2(WORDS);
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int POS_W = $clog2(CAPACITY + 1);
	localparam int PW_W = POS_W - BIT_W;
	localparam int SCAN_W = $clog2(WORDS + 1);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		MODE_ADD,
		MODE_DEL,
		MODE_TEST,
		MODE_CLEAR,
		MODE_REWIND,
		MODE_NEXT
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_PRESENT,
		STAT_BELOW,
		STAT_BEYOND
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MOD,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]      mode;
		logic [ID_W-1:0] id;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             present;
		logic [ID_W-1:0]  next_id;
		logic             next_valid;
		logic [CNT_W-1:0] member_count;
		logic [ID_W-1:0]  min_unused;
		logic [ID_W-1:0]  max_id;
	} res_t;

	typedef struct packed {
		logic               rd_en;
		logic [WADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [WADDR_W-1:0] wr_addr;
		logic               clr;
	} bm_ctl_t;

	function automatic logic [BIT_W-1:0] first_one(input word_t w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [BIT_W-1:0] last_one(input word_t w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (w[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hdl/obis_bitmap_store.sv =====
// bitmap word memory with per-word valid bits and registered read
module obis_bitmap_store (
	input  logic             clk,
	input  logic             arst_n,
	input  obis_pkg::bm_ctl_t ctl,
	input  obis_pkg::word_t  wdata,
	output obis_pkg::word_t  rdata
);

	obis_pkg::word_t mem_q [obis_pkg::WORDS];
	logic [obis_pkg::WORDS-1:0] vld_q;
	obis_pkg::word_t rd_s1;
	logic rvld_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_s1 <= mem_q[ctl.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_s1 <= vld_q[ctl.rd_addr];
			end
		end
	end

	// unwritten or cleared words read as zero
	assign rdata = rvld_s1 ? rd_s1 : '0;

endmodule

// ===== hdl/offset_bitmap_id_set_unit.sv =====
// top level: offset bitmap id set with add, delete, test, clear and iterator
// steps: read, modify, scan of every word, finish, then the registered done strobe
// requests are taken one at a time; busy stays high until the done strobe
// the scan walks the bitmap memory one word per cycle through its single read port
// reset: empty set, iterator at zero, base id zero; the receiver cannot stall
module offset_bitmap_id_set_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  obis_pkg::req_t             req,
	output logic                       done,
	output obis_pkg::res_t             res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [obis_pkg::ID_W-1:0]  cfg_data
);

	obis_pkg::state_t state_q, state_d;
	logic [obis_pkg::ID_W-1:0] base_q;
	logic [2:0] mode_q;
	logic below_q, beyond_q;
	logic [obis_pkg::WADDR_W-1:0] word_q;
	logic [obis_pkg::BIT_W-1:0] bit_q;
	logic [obis_pkg::POS_W-1:0] pop_q, iter_q;
	logic [obis_pkg::SCAN_W-1:0] scan_q;
	logic [1:0] status_q;
	logic present_q;
	logic lz_found_q, nx_found_q;
	logic [obis_pkg::IDX_W-1:0] lz_idx_q, hs_idx_q, nx_idx_q;
	obis_pkg::res_t res_q;
	logic done_q;

	obis_pkg::bm_ctl_t ctl;
	obis_pkg::word_t rdata, mod_wdata, bit_mask, nx_masked;
	logic mod_wr, hit;
	logic [1:0] mod_status;
	logic mod_present;
	logic [obis_pkg::POS_W-1:0] mod_pop;
	logic [obis_pkg::ID_W-1:0] off;
	logic [obis_pkg::SCAN_W-1:0] scan_m1;
	logic [obis_pkg::WADDR_W-1:0] scan_w;
	logic [obis_pkg::PW_W-1:0] iter_pw, scan_pw;
	logic accept;

	obis_bitmap_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wdata  (mod_wdata),
		.rdata  (rdata)
	);

	assign accept = start && (state_q == obis_pkg::S_IDLE);
	assign off = req.id - base_q;
	assign cfg_ready = 1'b1;
	assign busy = (state_q != obis_pkg::S_IDLE);
	assign done = done_q;
	assign res = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			obis_pkg::S_IDLE: begin
				if (start) begin
					state_d = obis_pkg::S_RD;
				end
			end
			obis_pkg::S_RD:   state_d = obis_pkg::S_MOD;
			obis_pkg::S_MOD:  state_d = obis_pkg::S_SCAN;
			obis_pkg::S_SCAN: begin
				if (scan_q == obis_pkg::SCAN_W'(obis_pkg::WORDS)) begin
					state_d = obis_pkg::S_FIN;
				end
			end
			obis_pkg::S_FIN:  state_d = obis_pkg::S_IDLE;
			default:          state_d = obis_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		ctl = '0;
		unique case (state_q)
			obis_pkg::S_RD: begin
				ctl.rd_en = 1'b1;
				ctl.rd_addr = word_q;
			end
			obis_pkg::S_MOD: begin
				ctl.wr_en = mod_wr;
				ctl.wr_addr = word_q;
				ctl.clr = (mode_q == obis_pkg::MODE_CLEAR);
			end
			obis_pkg::S_SCAN: begin
				ctl.rd_en = (scan_q < obis_pkg::SCAN_W'(obis_pkg::WORDS));
				ctl.rd_addr = scan_q[obis_pkg::WADDR_W-1:0];
			end
			default: ctl = '0;
		endcase
	end

	// read-modify-write of the addressed word
	always_comb begin
		bit_mask = obis_pkg::word_t'(1) << bit_q;
		hit = |(rdata & bit_mask);
		mod_wr = 1'b0;
		mod_wdata = rdata;
		mod_status = obis_pkg::STAT_OK;
		mod_present = 1'b0;
		mod_pop = pop_q;
		unique case (mode_q)
			obis_pkg::MODE_ADD: begin
				if (below_q) begin
					mod_status = obis_pkg::STAT_BELOW;
				end else if (beyond_q) begin
					mod_status = obis_pkg::STAT_BEYOND;
				end else if (hit) begin
					mod_status = obis_pkg::STAT_PRESENT;
				end else begin
					mod_wr = 1'b1;
					mod_wdata = rdata | bit_mask;
					mod_pop = pop_q + obis_pkg::POS_W'(1);
				end
			end
			obis_pkg::MODE_DEL: begin
				if (below_q) begin
					mod_status = obis_pkg::STAT_BELOW;
				end else if (!beyond_q && hit) begin
					mod_wr = 1'b1;
					mod_wdata = rdata & ~bit_mask;
					mod_pop = pop_q - obis_pkg::POS_W'(1);
				end
			end
			obis_pkg::MODE_TEST: begin
				if (below_q) begin
					mod_status = obis_pkg::STAT_BELOW;
				end else begin
					mod_present = !beyond_q && hit;
				end
			end
			obis_pkg::MODE_CLEAR: mod_pop = '0;
			default: mod_pop = pop_q;
		endcase
	end

	// scan of the word read in the previous cycle
	always_comb begin
		scan_m1 = scan_q - obis_pkg::SCAN_W'(1);
		scan_w = scan_m1[obis_pkg::WADDR_W-1:0];
		scan_pw = obis_pkg::PW_W'(scan_w);
		iter_pw = iter_q[obis_pkg::POS_W-1:obis_pkg::BIT_W];
		if (scan_pw == iter_pw) begin
			nx_masked = rdata & ({obis_pkg::WORD_BITS{1'b1}} << iter_q[obis_pkg::BIT_W-1:0]);
		end else if (scan_pw > iter_pw) begin
			nx_masked = rdata;
		end else begin
			nx_masked = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obis_pkg::S_IDLE;
			base_q <= '0;
			pop_q <= '0;
			iter_q <= '0;
			scan_q <= '0;
			lz_found_q <= 1'b0;
			nx_found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == obis_pkg::S_FIN);
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (state_q == obis_pkg::S_MOD) begin
				pop_q <= mod_pop;
				scan_q <= '0;
				lz_found_q <= 1'b0;
				nx_found_q <= 1'b0;
				if (mode_q == obis_pkg::MODE_REWIND) begin
					iter_q <= '0;
				end
			end
			if (state_q == obis_pkg::S_SCAN) begin
				scan_q <= scan_q + obis_pkg::SCAN_W'(1);
				if (scan_q != '0) begin
					if (!lz_found_q && (~rdata != '0)) begin
						lz_found_q <= 1'b1;
					end
					if (!nx_found_q && (nx_masked != '0)) begin
						nx_found_q <= 1'b1;
					end
				end
			end
			if (state_q == obis_pkg::S_FIN && mode_q == obis_pkg::MODE_NEXT) begin
				iter_q <= nx_found_q ? obis_pkg::POS_W'(nx_idx_q) + obis_pkg::POS_W'(1)
					: obis_pkg::POS_W'(obis_pkg::CAPACITY);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			below_q <= (req.id < base_q);
			beyond_q <= (off >= obis_pkg::ID_W'(obis_pkg::CAPACITY));
			word_q <= off[obis_pkg::IDX_W-1:obis_pkg::BIT_W];
			bit_q <= off[obis_pkg::BIT_W-1:0];
		end
		if (state_q == obis_pkg::S_MOD) begin
			status_q <= mod_status;
			present_q <= mod_present;
			hs_idx_q <= '0;
		end
		if (state_q == obis_pkg::S_SCAN && scan_q != '0) begin
			if (!lz_found_q && (~rdata != '0)) begin
				lz_idx_q <= {scan_w, obis_pkg::first_one(~rdata)};
			end
			if (rdata != '0) begin
				hs_idx_q <= {scan_w, obis_pkg::last_one(rdata)};
			end
			if (!nx_found_q && (nx_masked != '0)) begin
				nx_idx_q <= {scan_w, obis_pkg::first_one(nx_masked)};
			end
		end
		if (state_q == obis_pkg::S_FIN) begin
			res_q.status <= status_q;
			res_q.present <= present_q;
			res_q.next_valid <= nx_found_q && (mode_q == obis_pkg::MODE_NEXT);
			res_q.next_id <= (nx_found_q && (mode_q == obis_pkg::MODE_NEXT))
				? base_q + obis_pkg::ID_W'(nx_idx_q) : '0;
			res_q.member_count <= obis_pkg::CNT_W'(pop_q);
			res_q.min_unused <= base_q + (lz_found_q ? obis_pkg::ID_W'(lz_idx_q)
				: obis_pkg::ID_W'(obis_pkg::CAPACITY));
			res_q.max_id <= base_q + obis_pkg::ID_W'(hs_idx_q);
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == obis_pkg::S_FIN))
		else $error("done strobe without finish state");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == obis_pkg::S_RD))
		else $error("accepted request did not start a read");
	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop_q <= obis_pkg::POS_W'(obis_pkg::CAPACITY))
		else $error("population beyond capacity");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= obis_pkg::POS_W'(obis_pkg::CAPACITY))
		else $error("iterator beyond capacity");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == obis_pkg::S_SCAN && scan_q == obis_pkg::SCAN_W'(obis_pkg::WORDS))
		|=> (state_q == obis_pkg::S_FIN))
		else $error("scan did not end after the last word");
`endif

endmodule

// ===== verif/tb_offset_bitmap_id_set_unit.sv =====
`timescale 1ns / 100ps
// testbench: offset bitmap id set unit checked request by request against a set scoreboard
module tb_offset_bitmap_id_set_unit;
	import obis_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	class id_set_scoreboard;
		bit [CAPACITY-1:0] members;
		int cursor;
		int population;
		logic [ID_W-1:0] base = '0;
		res_t expected_q[$];
		int errors;

		function void set_base(logic [ID_W-1:0] value);
			base = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(req_t r);
			res_t e;
			logic [ID_W-1:0] off;
			int k;
			e = '0;
			off = r.id - base;
			if (r.mode <= MODE_TEST && r.id < base) begin
				e.status = STAT_BELOW;
			end else begin
				case (r.mode)
					MODE_ADD: begin
						if (off >= CAPACITY) begin
							e.status = STAT_BEYOND;
						end else if (members[off[IDX_W-1:0]]) begin
							e.status = STAT_PRESENT;
						end else begin
							members[off[IDX_W-1:0]] = 1'b1;
							population++;
						end
					end
					MODE_DEL: begin
						if (off < CAPACITY && members[off[IDX_W-1:0]]) begin
							members[off[IDX_W-1:0]] = 1'b0;
							population--;
						end
					end
					MODE_TEST: begin
						e.present = off < CAPACITY && members[off[IDX_W-1:0]];
					end
					MODE_CLEAR: begin
						members = '0;
						population = 0;
					end
					MODE_REWIND: begin
						cursor = 0;
					end
					MODE_NEXT: begin
						k = cursor;
						while (k < CAPACITY && !members[k]) k++;
						if (k < CAPACITY) begin
							e.next_valid = 1'b1;
							e.next_id = base + ID_W'(k);
							k++;
						end
						cursor = k;
					end
					default: begin
					end
				endcase
			end
			e.member_count = CNT_W'(population);
			k = 0;
			while (k < CAPACITY && members[k]) k++;
			e.min_unused = base + ID_W'(k);
			k = CAPACITY - 1;
			while (k > 0 && !members[k]) k--;
			e.max_id = base + ID_W'(k);
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare_field(string name, logic [ID_W-1:0] got, logic [ID_W-1:0] want);
			if (got !== want) begin
				report($sformatf("%s got %h expected %h", name, got, want));
			end
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report("result strobe with no request outstanding");
			end else begin
				want = expected_q.pop_front();
				compare_field("status", got.status, want.status);
				compare_field("present", got.present, want.present);
				compare_field("next_id", got.next_id, want.next_id);
				compare_field("next_valid", got.next_valid, want.next_valid);
				compare_field("member_count", got.member_count, want.member_count);
				compare_field("min_unused", got.min_unused, want.min_unused);
				compare_field("max_id", got.max_id, want.max_id);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [ID_W-1:0] cfg_data;

	id_set_scoreboard sb;
	int idle_pct;

	offset_bitmap_id_set_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_result(res);
			if (start && !busy) sb.note_request(req);
			if (cfg_valid && cfg_ready) sb.set_base(cfg_data);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic idle_cycle();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic send(req_t r);
		while ($urandom_range(99) < idle_pct) idle_cycle();
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic issue(logic [2:0] mode_code, logic [ID_W-1:0] id_value);
		req_t r;
		r.mode = mode_code;
		r.id = id_value;
		send(r);
	endtask

	task automatic drain();
		idle_cycle();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_base(logic [ID_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t make_request();
		req_t r;
		int pick;
		int off;
		pick = $urandom_range(99);
		off = $urandom_range(1) ? $urandom_range(127) : $urandom_range(CAPACITY + 15);
		r.id = sb.base + ID_W'(off);
		if (pick < 34) begin
			r.mode = MODE_ADD;
		end else if (pick < 54) begin
			r.mode = MODE_DEL;
		end else if (pick < 68) begin
			r.mode = MODE_TEST;
		end else if (pick < 80) begin
			r.mode = MODE_NEXT;
			r.id = $urandom();
		end else if (pick < 85) begin
			r.mode = MODE_REWIND;
			r.id = $urandom();
		end else if (pick < 87) begin
			r.mode = MODE_CLEAR;
			r.id = $urandom();
		end else if (pick < 90) begin
			r.mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
			r.id = $urandom();
		end else begin
			r.mode = 3'($urandom_range(MODE_TEST, MODE_ADD));
			r.id = $urandom();
		end
		return r;
	endfunction

	task automatic random_items(int count);
		repeat (count) send(make_request());
	endtask

	initial begin
		int step;
		int first;
		sb = new;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, base id at its reset value and then at 100
		issue(MODE_TEST, 32'd0);
		issue(MODE_NEXT, 32'd0);
		issue(MODE_REWIND, 32'd0);
		issue(MODE_ADD, 32'd0);
		issue(MODE_ADD, 32'd0);
		issue(MODE_ADD, CAPACITY - 1);
		issue(MODE_ADD, CAPACITY);
		issue(MODE_ADD, 32'hFFFF_FFFF);
		issue(MODE_TEST, CAPACITY - 1);
		issue(MODE_TEST, 32'd4000);
		issue(MODE_DEL, 32'd4000);
		issue(MODE_NEXT, 32'd0);
		issue(MODE_NEXT, 32'd0);
		issue(MODE_NEXT, 32'd0);
		issue(MODE_NEXT, 32'd0);
		issue(MODE_DEL, CAPACITY - 1);
		issue(MODE_DEL, CAPACITY - 1);
		issue(MODE_SPARE_LO, 32'hFFFF_FFFF);
		issue(MODE_SPARE_HI, 32'd0);
		issue(MODE_CLEAR, 32'd0);
		issue(MODE_ADD, WORD_BITS);
		issue(MODE_REWIND, 32'd0);
		issue(MODE_NEXT, 32'd0);
		write_base(32'd100);
		issue(MODE_ADD, 32'd5);
		issue(MODE_DEL, 32'd99);
		issue(MODE_TEST, 32'd0);
		issue(MODE_TEST, 32'd100 + WORD_BITS);

		write_base(ID_W'($urandom_range(5000)));
		random_items(300);

		idle_pct = 66;
		write_base(32'hFFFF_FFFF);
		random_items(120);

		// fill the whole set in a scrambled order so min_unused reaches the end and wraps
		idle_pct = 16;
		write_base(32'hFFFF_FC00);
		issue(MODE_CLEAR, 32'd0);
		step = 2 * $urandom_range(511) + 1;
		first = $urandom_range(CAPACITY - 1);
		for (int k = 0; k < CAPACITY; k++) begin
			issue(MODE_ADD, sb.base + ID_W'((first + k * step) % CAPACITY));
		end
		issue(MODE_REWIND, 32'd0);
		random_items(100);

		idle_pct = 66;
		write_base($urandom());
		random_items(150);

		idle_pct = 0;
		write_base(32'd0);
		random_items(100);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/obis_pkg.sv
hdl/obis_bitmap_store.sv
hdl/offset_bitmap_id_set_unit.sv
verif/tb_offset_bitmap_id_set_unit.sv
